/* rtl/core/utf8_string_script_classifier_macros.svh */
// Assertion macros for the checker file of the UTF-8 script classifier.
`ifndef UTF8_STRING_SCRIPT_CLASSIFIER_MACROS_SVH
`define UTF8_STRING_SCRIPT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssc assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssc assertion failed");

// Next-cycle implication that also holds across reset.
`define SSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ssc assertion failed");

`endif

/* rtl/core/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, constants and the code point classifier of the UTF-8 script
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    // Script classes reported per string
    typedef enum logic [2:0] {
        CLS_HIRAGANA = 3'd0,
        CLS_KATAKANA = 3'd1,
        CLS_DIGIT    = 3'd2,
        CLS_LETTER   = 3'd3,
        CLS_KANJI    = 3'd4,
        CLS_SYMBOL   = 3'd5,
        CLS_MIXED    = 3'd6
    } script_class_t;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    // Result transaction payload
    typedef struct packed {
        logic [2:0]  string_class;
        logic [15:0] char_count;
    } out_t;

    // Per-string decoder state
    typedef struct packed {
        logic [2:0]    bytes_pending;
        logic          decoding_active;
        logic [15:0]   code_accumulator;
        script_class_t first_class;
        logic          class_seen;
        logic          classes_differ;
        logic [15:0]   character_total;
    } state_t;

    // Lead byte thresholds (byte is a lead of N bytes when above these)
    localparam logic [7:0] LEAD_SIX   = 8'hfb;
    localparam logic [7:0] LEAD_FIVE  = 8'hf7;
    localparam logic [7:0] LEAD_FOUR  = 8'hef;
    localparam logic [7:0] LEAD_THREE = 8'hdf;
    localparam logic [7:0] LEAD_TWO   = 8'h7f;

    // Code point range bounds (exclusive)
    localparam logic [15:0] HIRA_LO   = 16'h303f;
    localparam logic [15:0] HIRA_HI   = 16'h30a0;
    localparam logic [15:0] KATA_LO   = 16'h309f;
    localparam logic [15:0] KATA_HI   = 16'h3100;
    localparam logic [15:0] DIGIT_LO  = 16'hff0f;
    localparam logic [15:0] DIGIT_HI  = 16'hff1a;
    localparam logic [15:0] LETTER_LO = 16'hff20;
    localparam logic [15:0] LETTER_HI = 16'hff5b;
    localparam logic [15:0] KANJI_LO  = 16'h4dff;
    localparam logic [15:0] KANJI_HI  = 16'ha000;
    localparam logic [15:0] KANJI_ITERATION_MARK = 16'h3005;

    localparam logic [15:0] CHAR_COUNT_MAX = 16'hffff;

    // Class of one decoded code point
    function automatic script_class_t class_of(input logic [15:0] cp);
        script_class_t k;
        if (cp > HIRA_LO && cp < HIRA_HI) begin
            k = CLS_HIRAGANA;
        end else if (cp > KATA_LO && cp < KATA_HI) begin
            k = CLS_KATAKANA;
        end else if (cp > DIGIT_LO && cp < DIGIT_HI) begin
            k = CLS_DIGIT;
        end else if (cp > LETTER_LO && cp < LETTER_HI) begin
            k = CLS_LETTER;
        end else if ((cp > KANJI_LO && cp < KANJI_HI) || cp == KANJI_ITERATION_MARK) begin
            k = CLS_KANJI;
        end else begin
            k = CLS_SYMBOL;
        end
        return k;
    endfunction

    // Fold one classed character into the string's class tracking
    function automatic state_t note_class(input state_t s, input logic [15:0] cp);
        state_t        r;
        script_class_t k;
        r = s;
        k = class_of(cp);
        if (!s.class_seen) begin
            r.first_class = k;
            r.class_seen  = 1'b1;
        end else if (k != s.first_class) begin
            r.classes_differ = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ssc_in_stage.sv */
// ----------------------------------------------------------------------------
// ssc_in_stage
// Input register of the classifier: holds one byte transaction until the
// decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_in_stage
    import ssc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      item_valid,
    output in_t       item,
    input  wire logic item_take
);

    logic valid_reg;
    logic valid_next;
    in_t  data_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

/* rtl/core/ssc_step.sv */
// ----------------------------------------------------------------------------
// ssc_step
// Decode step: applies one UTF-8 byte to the decoder state and forms the
// string result for a final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_step
    import ssc_pkg::*;
(
    input  wire state_t st,
    input  wire in_t    item,
    output state_t      st_next,
    output out_t        result
);

    state_t        n;
    logic          note_now;
    logic [15:0]   note_cp;
    script_class_t cls;
    logic [7:0]    b;

    assign b = item.data_byte;

    always_comb begin
        n        = st;
        note_now = 1'b0;
        note_cp  = 16'd0;

        if (st.bytes_pending == 3'd0) begin
            // Lead byte: count it and set the sequence length
            if (st.character_total != CHAR_COUNT_MAX) begin
                n.character_total = st.character_total + 16'd1;
            end
            if (b > LEAD_SIX) begin
                n.bytes_pending   = 3'd5;
                n.decoding_active = 1'b0;
            end else if (b > LEAD_FIVE) begin
                n.bytes_pending   = 3'd4;
                n.decoding_active = 1'b0;
            end else if (b > LEAD_FOUR) begin
                n.bytes_pending   = 3'd3;
                n.decoding_active = 1'b0;
            end else if (b > LEAD_THREE) begin
                n.code_accumulator = {b[3:0], 12'd0};
                n.bytes_pending    = 3'd2;
                n.decoding_active  = 1'b1;
            end else if (b > LEAD_TWO) begin
                n.code_accumulator = {5'd0, b[4:0], 6'd0};
                n.bytes_pending    = 3'd1;
                n.decoding_active  = 1'b1;
            end else begin
                note_now = 1'b1;
                note_cp  = {8'd0, b};
            end
        end else if (st.decoding_active) begin
            // Continuation byte of a decoded character
            if (st.bytes_pending == 3'd2) begin
                n.code_accumulator = st.code_accumulator | {4'd0, b[5:0], 6'd0};
                n.bytes_pending    = 3'd1;
            end else begin
                n.code_accumulator = st.code_accumulator | {10'd0, b[5:0]};
                n.bytes_pending    = 3'd0;
                n.decoding_active  = 1'b0;
                note_now           = 1'b1;
                note_cp            = st.code_accumulator | {10'd0, b[5:0]};
            end
        end else begin
            // Drop a byte of a skipped long sequence
            n.bytes_pending = st.bytes_pending - 3'd1;
        end

        if (note_now) begin
            n = note_class(n, note_cp);
        end

        // Close a truncated decoded character, missing bytes read as zero
        if (item.last_byte && n.decoding_active && n.bytes_pending != 3'd0) begin
            n = note_class(n, n.code_accumulator);
        end

        st_next = n;
    end

    assign cls = (!n.class_seen || n.classes_differ) ? CLS_MIXED : n.first_class;

    assign result.string_class = cls;
    assign result.char_count   = n.character_total;

endmodule

`default_nettype wire

/* rtl/core/utf8_string_script_classifier.sv */
// ----------------------------------------------------------------------------
// utf8_string_script_classifier
// UTF-8 string script classifier: one result per string with the shared
// script class (mixed when none is shared) and the character count.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one string byte per transaction, with
//   last_byte marking the final byte of a string. m_valid/m_ready/m_data
//   carry one result per string: string_class and char_count.
//   Throughput: one byte per cycle while no final byte waits on a full
//   result register, set by the single decode step between the input
//   register and the result register. The result is presented once the
//   decode step has moved the final byte from the input register into
//   the result register.
//   Non-final bytes keep flowing while a result waits on a stalled m_ready.
//   A final byte waits in the input register while the result register is
//   full and unread, and s_ready stays low until that byte moves on.
//   Reset (aresetn low, synchronous) empties both registers and clears the
//   decoder state; the first byte after reset starts a new string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_string_script_classifier
    import ssc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic   item_valid;
    in_t    item;
    logic   item_take;
    state_t state_reg;
    state_t state_next;
    out_t   result;
    out_t   out_reg;
    logic   m_valid_reg;
    logic   m_valid_next;

    ssc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ssc_step u_step (
        .st      (state_reg),
        .item    (item),
        .st_next (state_next),
        .result  (result)
    );

    // Advance a byte unless it is final and the result slot stays full
    assign item_take = item_valid && (!item.last_byte || !m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (item_take && item.last_byte) begin
            m_valid_next = 1'b1;
        end
    end

    // Hold decoder state and result valid flag; clear the state after each final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (item_take) begin
                state_reg <= item.last_byte ? state_t'('0) : state_next;
            end
        end
    end

    // Load result on a final byte
    always_ff @(posedge aclk) begin
        if (item_take && item.last_byte) begin
            out_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* rtl/core/ssc_checker.sv */
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the UTF-8 script classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_string_script_classifier_macros.svh"

module ssc_checker
    import ssc_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // Every string holds at least one lead byte
    `SSC_ASSERT_IMPL(a_count_nonzero, aclk, aresetn, m_valid, m_data.char_count != 16'd0)

    // Class code stays within the defined classes
    `SSC_ASSERT_IMPL(a_class_range, aclk, aresetn, m_valid, m_data.string_class != 3'd7)

    // Hold a stalled result
    `SSC_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid)

    // Reset empties the result register
    `SSC_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind utf8_string_script_classifier ssc_checker u_ssc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 string script classifier. A driver feeds
// string bytes from a queue and a monitor compares every result transaction
// with the class and count that a local decoder predicts for each string.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ssc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Stimulus and expectation stores
    in_t  pending_bytes[$];
    out_t expected_summaries[$];
    logic [7:0] draft[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;

    // Local decoder state for the string in flight
    logic [2:0]    dec_pending  = '0;
    logic          dec_active   = 1'b0;
    logic [15:0]   dec_code     = '0;
    script_class_t dec_first    = CLS_HIRAGANA;
    logic          dec_seen     = 1'b0;
    logic          dec_conflict = 1'b0;
    logic [15:0]   dec_total    = '0;

    utf8_string_script_classifier uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Fail on a hung run
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Script class of one code point
    function automatic script_class_t script_of(input logic [15:0] cp);
        script_class_t k;
        k = CLS_SYMBOL;
        if (cp > HIRA_LO && cp < HIRA_HI) begin
            k = CLS_HIRAGANA;
        end else if (cp > KATA_LO && cp < KATA_HI) begin
            k = CLS_KATAKANA;
        end else if (cp > DIGIT_LO && cp < DIGIT_HI) begin
            k = CLS_DIGIT;
        end else if (cp > LETTER_LO && cp < LETTER_HI) begin
            k = CLS_LETTER;
        end else if ((cp > KANJI_LO && cp < KANJI_HI) || cp == KANJI_ITERATION_MARK) begin
            k = CLS_KANJI;
        end
        return k;
    endfunction

    // Merge one character's class into the string summary
    task automatic merge_script(input logic [15:0] cp);
        script_class_t k;
        k = script_of(cp);
        if (!dec_seen) begin
            dec_first = k;
            dec_seen  = 1'b1;
        end else if (k != dec_first) begin
            dec_conflict = 1'b1;
        end
    endtask

    // Advance the decoder by one accepted byte
    task automatic decode_byte(input in_t item);
        logic [7:0] b;
        out_t       summary;
        b = item.data_byte;
        if (dec_pending == 3'd0) begin
            if (dec_total != CHAR_COUNT_MAX) dec_total = dec_total + 16'd1;
            if (b > LEAD_SIX) begin
                dec_pending = 3'd5;
                dec_active  = 1'b0;
            end else if (b > LEAD_FIVE) begin
                dec_pending = 3'd4;
                dec_active  = 1'b0;
            end else if (b > LEAD_FOUR) begin
                dec_pending = 3'd3;
                dec_active  = 1'b0;
            end else if (b > LEAD_THREE) begin
                dec_code    = {b[3:0], 12'd0};
                dec_pending = 3'd2;
                dec_active  = 1'b1;
            end else if (b > LEAD_TWO) begin
                dec_code    = {5'd0, b[4:0], 6'd0};
                dec_pending = 3'd1;
                dec_active  = 1'b1;
            end else begin
                merge_script({8'd0, b});
            end
        end else if (dec_active) begin
            if (dec_pending == 3'd2) begin
                dec_code    = dec_code | {4'd0, b[5:0], 6'd0};
                dec_pending = 3'd1;
            end else begin
                dec_code    = dec_code | {10'd0, b[5:0]};
                dec_pending = 3'd0;
                dec_active  = 1'b0;
                merge_script(dec_code);
            end
        end else begin
            dec_pending = dec_pending - 3'd1;
        end

        if (item.last_byte) begin
            // A truncated decoded character still counts with zero fill
            if (dec_active && dec_pending != 3'd0) merge_script(dec_code);
            summary.string_class = (!dec_seen || dec_conflict) ? CLS_MIXED : dec_first;
            summary.char_count   = dec_total;
            expected_summaries = {expected_summaries, summary};
            dec_pending  = '0;
            dec_active   = 1'b0;
            dec_code     = '0;
            dec_first    = CLS_HIRAGANA;
            dec_seen     = 1'b0;
            dec_conflict = 1'b0;
            dec_total    = '0;
        end
    endtask

    // Move the draft string into the byte queue, marking its final byte
    task automatic commit_string();
        in_t item;
        for (int i = 0; i < draft.size(); i++) begin
            item.data_byte = draft[i];
            item.last_byte = (i == draft.size() - 1);
            pending_bytes = {pending_bytes, item};
        end
        draft.delete();
    endtask

    // Continuation byte; the top two bits are mostly the proper marker
    function automatic logic [7:0] tail_byte(input logic [5:0] bits);
        logic [1:0] top;
        top = ($urandom_range(9) < 8) ? 2'b10 : 2'($urandom_range(3));
        return {top, bits};
    endfunction

    // Code point drawn from one script class, often at a range edge
    function automatic logic [15:0] pick_code(input script_class_t k);
        logic [15:0] cp;
        int unsigned edge_pick;
        edge_pick = $urandom_range(7);
        case (k)
            CLS_HIRAGANA: begin
                cp = (edge_pick == 0) ? 16'h3040 : (edge_pick == 1) ? 16'h309f
                   : 16'($urandom_range(16'h3040, 16'h309f));
            end
            CLS_KATAKANA: begin
                cp = (edge_pick == 0) ? 16'h30a0 : (edge_pick == 1) ? 16'h30ff
                   : 16'($urandom_range(16'h30a0, 16'h30ff));
            end
            CLS_DIGIT: begin
                cp = (edge_pick == 0) ? 16'hff10 : (edge_pick == 1) ? 16'hff19
                   : 16'($urandom_range(16'hff10, 16'hff19));
            end
            CLS_LETTER: begin
                cp = (edge_pick == 0) ? 16'hff21 : (edge_pick == 1) ? 16'hff5a
                   : 16'($urandom_range(16'hff21, 16'hff5a));
            end
            CLS_KANJI: begin
                cp = (edge_pick == 0) ? 16'h3005 : (edge_pick == 1) ? 16'h9fff
                   : (edge_pick == 2) ? 16'h4e00 : 16'($urandom_range(16'h4e00, 16'h9fff));
            end
            default: begin
                case (edge_pick)
                    0: cp = 16'h303f;
                    1: cp = 16'h3100;
                    2: cp = 16'hff0f;
                    3: cp = 16'hff1a;
                    4: cp = 16'hff20;
                    5: cp = 16'hff5b;
                    6: cp = ($urandom_range(1) == 0) ? 16'h4dff : 16'ha000;
                    default: cp = 16'($urandom_range(16'hffff));
                endcase
            end
        endcase
        return cp;
    endfunction

    // Append one character to the draft: kinds 0..5 follow the class,
    // 6 is ASCII, 7 a two-byte form, 8 a skipped long sequence
    task automatic add_char(input int unsigned kind);
        logic [15:0] cp;
        int unsigned len;
        if (kind < 6) begin
            cp = pick_code(script_class_t'(kind));
            draft = {draft, {4'he, cp[15:12]}};
            draft = {draft, tail_byte(cp[11:6])};
            draft = {draft, tail_byte(cp[5:0])};
        end else if (kind == 6) begin
            draft = {draft, 8'($urandom_range(8'h7f))};
        end else if (kind == 7) begin
            draft = {draft, 8'($urandom_range(8'h80, 8'hdf))};
            draft = {draft, 8'($urandom_range(8'hff))};
        end else begin
            len = $urandom_range(4, 6);
            case (len)
                4: draft = {draft, 8'($urandom_range(8'hf0, 8'hf7))};
                5: draft = {draft, 8'($urandom_range(8'hf8, 8'hfb))};
                default: draft = {draft, 8'($urandom_range(8'hfc, 8'hff))};
            endcase
            for (int i = 1; i < len; i++) draft = {draft, 8'($urandom_range(8'hff))};
        end
    endtask

    // Queue random strings until at least the given number of bytes wait
    task automatic queue_random_strings(input int unsigned byte_goal);
        int unsigned goal;
        int unsigned theme;
        int unsigned chars;
        int unsigned kind;
        int unsigned mark;
        int unsigned cut;
        goal = pending_bytes.size() + byte_goal;
        while (pending_bytes.size() < goal) begin
            if ($urandom_range(9) == 0) begin
                // Noise string of raw bytes
                chars = $urandom_range(1, 10);
                for (int i = 0; i < chars; i++) draft = {draft, 8'($urandom_range(8'hff))};
            end else begin
                theme = $urandom_range(5);
                chars = $urandom_range(1, 6);
                mark  = 0;
                for (int i = 0; i < chars; i++) begin
                    kind = theme;
                    if ($urandom_range(9) < 2) kind = $urandom_range(8);
                    else if (theme == CLS_SYMBOL && $urandom_range(2) == 0) kind = 6;
                    mark = draft.size();
                    add_char(kind);
                end
                // Cut the last character short now and then
                if ($urandom_range(6) == 0 && draft.size() - mark > 1) begin
                    cut = $urandom_range(1, draft.size() - mark - 1);
                    for (int i = 0; i < cut; i++) void'(draft.pop_back());
                end
            end
            commit_string();
        end
    endtask

    // Directed strings: each class, truncation, long sequences, mixing
    task automatic queue_directed_strings();
        draft = '{8'h00};                          commit_string();
        draft = '{8'hff};                          commit_string();
        draft = '{8'hf8, 8'h80};                   commit_string();
        draft = '{8'he3, 8'h81};                   commit_string();
        draft = '{8'he3, 8'h83, 8'hbc};            commit_string();
        draft = '{8'hef, 8'hbc, 8'h90};            commit_string();
        draft = '{8'hef, 8'hbd, 8'h9a};            commit_string();
        draft = '{8'he3, 8'h80, 8'h85};            commit_string();
        draft = '{8'hf0, 8'h9f, 8'h98, 8'h80, 8'h7f}; commit_string();
        draft = '{8'h41, 8'he4, 8'hb8, 8'h80};     commit_string();
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_summaries.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Drive input transactions; predict each accepted byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) decode_byte(s_data);
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result transaction against the oldest expected summary
    always @(posedge aclk) begin : check_result
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_summaries.size() == 0) begin
                report_mismatch("unexpected result, class", m_data.string_class, -1);
            end else begin
                want = expected_summaries.pop_front();
                if (m_data.string_class !== want.string_class)
                    report_mismatch("string_class", m_data.string_class, want.string_class);
                if (m_data.char_count !== want.char_count)
                    report_mismatch("char_count", m_data.char_count, want.char_count);
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No idling: directed, random
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_directed_strings();
        queue_random_strings(350);
        wait_drained();

        // Sender idle
        send_idle_pct  = 51;
        recv_stall_pct = 0;
        queue_random_strings(350);
        wait_drained();

        // Receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        queue_random_strings(350);
        wait_drained();

        // Both sides
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        queue_random_strings(350);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/ssc_in_stage.sv
rtl/core/ssc_step.sv
rtl/core/utf8_string_script_classifier.sv
rtl/core/ssc_checker.sv
bench/tb_top.sv
